@@ sv/pct_pkg.sv @@
`default_nettype none
package pct_pkg;

  localparam int unsigned TimeW  = 26;
  localparam int unsigned CountW = 16;
  localparam int unsigned CycW   = 4;
  localparam int unsigned ElapW  = 16;
  localparam int unsigned ActW   = 3;
  localparam int unsigned PhaseW = 2;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [TimeW-1:0]  TimeMax  = {TimeW{1'b1}};
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam logic [TimeW-1:0] WorkRst  = TimeW'(1500000);
  localparam logic [TimeW-1:0] ShortRst = TimeW'(300000);
  localparam logic [TimeW-1:0] LongRst  = TimeW'(900000);
  localparam logic [CycW-1:0]  CycRst   = CycW'(4);
  localparam logic [TimeW-1:0] StepRst  = TimeW'(60000);

  typedef enum logic [ActW-1:0] {
    ACT_TICK    = 3'd0,
    ACT_CONFIRM = 3'd1,
    ACT_BACK    = 3'd2,
    ACT_UP      = 3'd3,
    ACT_DOWN    = 3'd4
  } action_e;

  typedef enum logic [PhaseW-1:0] {
    PH_IDLE  = 2'd0,
    PH_WORK  = 2'd1,
    PH_SHORT = 2'd2,
    PH_LONG  = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WORK  = 3'd0,
    REG_SHORT = 3'd1,
    REG_LONG  = 3'd2,
    REG_CYC   = 3'd3,
    REG_STEP  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [TimeW-1:0] work_ms;
    logic [TimeW-1:0] short_ms;
    logic [TimeW-1:0] long_ms;
    logic [CycW-1:0]  cycles;
    logic [TimeW-1:0] step_ms;
  } cfg_t;

  typedef struct packed {
    phase_e            phase;
    logic              paused;
    logic [TimeW-1:0]  remaining;
    logic [CountW-1:0] completed;
    logic [CycW-1:0]   cycle;
  } state_t;

endpackage
`default_nettype wire

@@ sv/pct_core.sv @@
`default_nettype none
module pct_core import pct_pkg::*; (
  input  wire logic [ActW-1:0]  action_i,
  input  wire logic [ElapW-1:0] elapsed_i,
  input  wire cfg_t             cfg_i,
  input  wire state_t           state_i,
  output state_t                state_o,
  output logic                  expired_o,
  output logic                  exit_o
);

  logic [TimeW:0]   up_sum;
  logic [CycW-1:0]  cyc_inc;
  logic [TimeW-1:0] elap_ext;

  assign up_sum   = {1'b0, state_i.remaining} + {1'b0, cfg_i.step_ms};
  assign cyc_inc  = state_i.cycle + CycW'(1);
  assign elap_ext = TimeW'(elapsed_i);

  always_comb begin
    state_o   = state_i;
    expired_o = 1'b0;
    exit_o    = 1'b0;
    case (action_i)
      ACT_TICK: begin
        if (state_i.phase != PH_IDLE && !state_i.paused) begin
          if (elap_ext >= state_i.remaining) begin
            expired_o = 1'b1;
            state_o.paused = 1'b0;
            if (state_i.phase == PH_WORK) begin
              if (state_i.completed != CountMax) begin
                state_o.completed = state_i.completed + CountW'(1);
              end
              if (cyc_inc >= cfg_i.cycles) begin
                state_o.cycle     = '0;
                state_o.phase     = PH_LONG;
                state_o.remaining = cfg_i.long_ms;
              end else begin
                state_o.cycle     = cyc_inc;
                state_o.phase     = PH_SHORT;
                state_o.remaining = cfg_i.short_ms;
              end
            end else begin
              state_o.phase     = PH_WORK;
              state_o.remaining = cfg_i.work_ms;
            end
          end else begin
            state_o.remaining = state_i.remaining - elap_ext;
          end
        end
      end
      ACT_CONFIRM: begin
        if (state_i.phase == PH_IDLE) begin
          state_o.phase     = PH_WORK;
          state_o.paused    = 1'b0;
          state_o.remaining = cfg_i.work_ms;
        end else begin
          state_o.paused = ~state_i.paused;
        end
      end
      ACT_BACK: begin
        if (state_i.phase == PH_IDLE) begin
          exit_o = 1'b1;
        end else begin
          state_o.phase     = PH_IDLE;
          state_o.paused    = 1'b0;
          state_o.remaining = cfg_i.work_ms;
        end
      end
      ACT_UP: begin
        state_o.remaining = up_sum[TimeW] ? TimeMax : up_sum[TimeW-1:0];
      end
      ACT_DOWN: begin
        state_o.remaining = (state_i.remaining > cfg_i.step_ms) ?
                            state_i.remaining - cfg_i.step_ms : '0;
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ sv/pomodoro_cycle_timer.sv @@
// Work / break countdown timer driven by one event word at a time.
// Slave channel: s_tuser carries the event kind (tick, confirm, back, up,
// down), s_tdata the milliseconds elapsed since the last tick. Every event
// word yields exactly one result word on the master channel holding the
// state after the event plus the expiry and exit flags.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 work length, 1 short break, 2 long break, 3 work phases per long break,
// 4 up/down step); write only while no event is in flight.
// An event passes the input register, then the result register, before it
// shows on m_tvalid. Throughput: one event per cycle while results are
// taken, set by the single input and result registers around the core.
// Reset: phase idle, unpaused, remaining 1500000 ms, counts zero, and the
// registers take their default lengths.
// Stall: a held result blocks the event stage only; one further event waits
// in the input register, then s_tready drops until the result is taken.
`default_nettype none
module pomodoro_cycle_timer import pct_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [15:0]        s_tdata,   // [15:0] elapsed_ms
  input  wire logic [2:0]         s_tuser,   // [2:0] action
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  // [1:0] phase, [2] paused, [28:3] remaining_ms, [44:29] completed_count,
  // [48:45] cycle_position, [49] phase_expired, [50] exit_request, rest zero
  output logic [55:0]             m_tdata,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [TimeW-1:0]   cfg_data_i
);

  cfg_t              cfg_q;
  state_t            state_q, state_d;
  logic              in_valid_q;
  logic [ActW-1:0]   in_act_q;
  logic [ElapW-1:0]  in_elap_q;
  logic              out_valid_q;
  logic              expired_d, exit_d;
  logic              expired_q, exit_q;
  logic              advance;

  assign advance  = in_valid_q && (!out_valid_q || m_tready);
  assign s_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.work_ms  <= WorkRst;
      cfg_q.short_ms <= ShortRst;
      cfg_q.long_ms  <= LongRst;
      cfg_q.cycles   <= CycRst;
      cfg_q.step_ms  <= StepRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WORK:  cfg_q.work_ms  <= cfg_data_i;
        REG_SHORT: cfg_q.short_ms <= cfg_data_i;
        REG_LONG:  cfg_q.long_ms  <= cfg_data_i;
        REG_CYC:   cfg_q.cycles   <= cfg_data_i[CycW-1:0];
        REG_STEP:  cfg_q.step_ms  <= cfg_data_i;
        default:   cfg_q          <= cfg_q;
      endcase
    end
  end

  pct_core u_core (
    .action_i  (in_act_q),
    .elapsed_i (in_elap_q),
    .cfg_i     (cfg_q),
    .state_i   (state_q),
    .state_o   (state_d),
    .expired_o (expired_d),
    .exit_o    (exit_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q.phase     <= PH_IDLE;
      state_q.paused    <= 1'b0;
      state_q.remaining <= WorkRst;
      state_q.completed <= '0;
      state_q.cycle     <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid && s_tready) begin
      in_act_q  <= s_tuser;
      in_elap_q <= s_tdata;
    end
    if (advance) begin
      expired_q <= expired_d;
      exit_q    <= exit_d;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {5'd0, exit_q, expired_q, state_q.cycle, state_q.completed,
                     state_q.remaining, state_q.paused, state_q.phase};

  a_idle_unpaused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_IDLE |-> !state_q.paused)
    else $error("paused while idle");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(expired_q && exit_q))
    else $error("expiry and exit in one result");

  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> state_q.completed >= $past(state_q.completed))
    else $error("completed count went down");

  a_hold_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_act_q) && $stable(in_elap_q))
    else $error("pending event lost");

endmodule
`default_nettype wire
